>>> sv/hertz_contact_force_assert.svh
// ----------------------------------------------------------------------------
// hertz_contact_force_assert.svh
// Assertion macros used by the Hertz contact force RTL.
// ----------------------------------------------------------------------------
`ifndef HERTZ_CONTACT_FORCE_ASSERT_SVH
`define HERTZ_CONTACT_FORCE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define HCF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hcf_pkg.sv
// ----------------------------------------------------------------------------
// hcf_pkg
// Types and constants for the Hertz contact force pipeline.
// ----------------------------------------------------------------------------
package hcf_pkg;

    localparam int IN_W  = 192;
    localparam int OUT_W = 72;

    localparam logic [1:0] STATUS_FORCE      = 2'd0;
    localparam logic [1:0] STATUS_NO_OVERLAP = 2'd1;
    localparam logic [1:0] STATUS_ZERO_DIV   = 2'd2;

    // Division by three, one 16-bit digit per stage.
    localparam int          PROD_W      = 112;
    localparam int          DIV3_STEPS  = 7;
    localparam logic [14:0] DIV3_RECIP  = 15'd21845;

    typedef struct packed {
        logic valid;
        logic no_overlap;
        logic zero_div;
    } item_ctl_t;

endpackage

>>> sv/hcf_div.sv
// ----------------------------------------------------------------------------
// hcf_div
// Pipelined restoring divider, one quotient bit per register stage.
// The upper NUM_W-QUO_W numerator bits must be below the divisor.
// ----------------------------------------------------------------------------
module hcf_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 33,
    parameter int QUO_W = 32
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg  [QUO_W];
    logic [QUO_W-1:0] ql_reg   [QUO_W];
    logic [DEN_W-1:0] den_reg  [QUO_W];
    logic [DEN_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0] ql_next  [QUO_W];
    logic [DEN_W-1:0] rem_src  [QUO_W];
    logic [QUO_W-1:0] ql_src   [QUO_W];
    logic [DEN_W-1:0] den_src  [QUO_W];
    logic [DEN_W:0]   trial    [QUO_W];
    logic [DEN_W:0]   diff     [QUO_W];
    logic             ge       [QUO_W];

    always_comb
    begin
        for (int i = 0; i < QUO_W; i++)
        begin
            if (i == 0)
            begin
                rem_src[i] = DEN_W'(num[NUM_W-1:QUO_W]);
                ql_src[i]  = num[QUO_W-1:0];
                den_src[i] = den;
            end
            else
            begin
                rem_src[i] = rem_reg[i-1];
                ql_src[i]  = ql_reg[i-1];
                den_src[i] = den_reg[i-1];
            end
            trial[i]    = {rem_src[i], ql_src[i][QUO_W-1]};
            diff[i]     = trial[i] - {1'b0, den_src[i]};
            ge[i]       = (trial[i] >= {1'b0, den_src[i]});
            rem_next[i] = ge[i] ? diff[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
            ql_next[i]  = {ql_src[i][QUO_W-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QUO_W; i++)
            begin
                rem_reg[i] <= rem_next[i];
                ql_reg[i]  <= ql_next[i];
                den_reg[i] <= den_src[i];
            end
        end
    end

    assign quo = ql_reg[QUO_W-1];

endmodule

>>> sv/hcf_isqrt.sv
// ----------------------------------------------------------------------------
// hcf_isqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module hcf_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] value,
    output logic [31:0] root
);

    localparam int STEPS = 32;

    logic [34:0] rem_reg   [STEPS];
    logic [31:0] root_reg  [STEPS];
    logic [63:0] rest_reg  [STEPS];
    logic [34:0] rem_src   [STEPS];
    logic [31:0] root_src  [STEPS];
    logic [63:0] rest_src  [STEPS];
    logic [34:0] shifted   [STEPS];
    logic [34:0] trial     [STEPS];
    logic        ge        [STEPS];
    logic [34:0] rem_next  [STEPS];
    logic [31:0] root_next [STEPS];

    always_comb
    begin
        for (int i = 0; i < STEPS; i++)
        begin
            if (i == 0)
            begin
                rem_src[i]  = '0;
                root_src[i] = '0;
                rest_src[i] = value;
            end
            else
            begin
                rem_src[i]  = rem_reg[i-1];
                root_src[i] = root_reg[i-1];
                rest_src[i] = rest_reg[i-1];
            end
            // The partial remainder never exceeds twice the partial root.
            shifted[i]   = {rem_src[i][32:0], rest_src[i][63:62]};
            trial[i]     = {1'b0, root_src[i], 2'b01};
            ge[i]        = (shifted[i] >= trial[i]);
            rem_next[i]  = ge[i] ? (shifted[i] - trial[i]) : shifted[i];
            root_next[i] = {root_src[i][30:0], ge[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                rest_reg[i] <= {rest_src[i][61:0], 2'b00};
            end
        end
    end

    assign root = root_reg[STEPS-1];

endmodule

>>> sv/hertz_contact_force.sv
// ----------------------------------------------------------------------------
// hertz_contact_force
// Hertzian sphere-sphere contact force, fully pipelined.
//
// The block takes one sphere pair per clock unless a held output stalls it,
// and returns one force per input transfer. The path runs through the three
// input stages, the 32-step radius divider, the 32-step square root, four
// multiply and add stages, the seven-stage division by three (one 16-bit
// digit per stage) and the output register; the 47-bit modulus divider runs
// beside the radius divider and the square root.
// A held output stalls the whole pipeline, so no item is lost or repeated.
// ----------------------------------------------------------------------------
`include "hertz_contact_force_assert.svh"

module hertz_contact_force #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_radius, second_radius, left_modulus, right_modulus, left_poisson,
    // right_poisson, separation; two zero bits on top
    input  logic [191:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // force_res, status; six zero bits on top
    output logic [71:0] m_tdata
);

    localparam int SHR     = 2 * FRAC_BITS - 16;
    localparam int D_LEN   = 65;
    localparam int MOD_LEN = 19;
    localparam int CTL_LEN = 75;

    logic adv;

    // Field unpacking.
    logic [31:0]        first_radius;
    logic [31:0]        second_radius;
    logic [31:0]        left_modulus;
    logic [31:0]        right_modulus;
    logic [14:0]        left_poisson;
    logic [14:0]        right_poisson;
    logic signed [31:0] separation;

    assign first_radius  = s_tdata[31:0];
    assign second_radius = s_tdata[63:32];
    assign left_modulus  = s_tdata[95:64];
    assign right_modulus = s_tdata[127:96];
    assign left_poisson  = s_tdata[142:128];
    assign right_poisson = s_tdata[157:143];
    assign separation    = s_tdata[189:158];

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Stage 1: products of the raw fields.
    logic [29:0]       vv1;
    logic [29:0]       vv2;
    logic [31:0]       d_1_reg;
    logic [63:0]       r1r2_1_reg;
    logic [32:0]       rsum_1_reg;
    logic [63:0]       e1e2_1_reg;
    logic [30:0]       w1_1_reg;
    logic [30:0]       w2_1_reg;
    logic [31:0]       e1_1_reg;
    logic [31:0]       e2_1_reg;
    hcf_pkg::item_ctl_t ctl_1_reg;
    hcf_pkg::item_ctl_t ctl_1_next;

    assign vv1 = left_poisson * left_poisson;
    assign vv2 = right_poisson * right_poisson;

    always_comb
    begin
        ctl_1_next.valid      = s_tvalid;
        ctl_1_next.no_overlap = !separation[31];
        ctl_1_next.zero_div   = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_1_reg    <= ~separation + 32'd1;
            r1r2_1_reg <= first_radius * second_radius;
            rsum_1_reg <= {1'b0, first_radius} + {1'b0, second_radius};
            e1e2_1_reg <= left_modulus * right_modulus;
            w1_1_reg   <= (31'd1 << 30) - {1'b0, vv1};
            w2_1_reg   <= (31'd1 << 30) - {1'b0, vv2};
            e1_1_reg   <= left_modulus;
            e2_1_reg   <= right_modulus;
        end
    end

    // Stage 2: cross terms of the modulus divisor.
    logic [31:0]       d_2_reg;
    logic [63:0]       r1r2_2_reg;
    logic [32:0]       rsum_2_reg;
    logic [63:0]       e1e2_2_reg;
    logic [62:0]       pe1_2_reg;
    logic [62:0]       pe2_2_reg;
    hcf_pkg::item_ctl_t ctl_2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_2_reg    <= d_1_reg;
            r1r2_2_reg <= r1r2_1_reg;
            rsum_2_reg <= rsum_1_reg;
            e1e2_2_reg <= e1e2_1_reg;
            pe1_2_reg  <= e2_1_reg * w1_1_reg;
            pe2_2_reg  <= e1_1_reg * w2_1_reg;
        end
    end

    // Stage 3: divisor sum and zero-divisor detection.
    logic [63:0]       den_next;
    logic [31:0]       d_3_reg;
    logic [63:0]       r1r2_3_reg;
    logic [32:0]       rsum_3_reg;
    logic [63:0]       e1e2_3_reg;
    logic [63:0]       den_3_reg;
    hcf_pkg::item_ctl_t ctl_3_reg;
    hcf_pkg::item_ctl_t ctl_3_next;

    assign den_next = {1'b0, pe1_2_reg} + {1'b0, pe2_2_reg};

    always_comb
    begin
        ctl_3_next          = ctl_2_reg;
        ctl_3_next.zero_div = (rsum_2_reg == '0) || (den_next == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_3_reg    <= d_2_reg;
            r1r2_3_reg <= r1r2_2_reg;
            rsum_3_reg <= rsum_2_reg;
            e1e2_3_reg <= e1e2_2_reg;
            den_3_reg  <= den_next;
        end
    end

    // Effective radius and effective modulus.
    logic [31:0] radius;
    logic [46:0] modulus;

    hcf_div #(
        .NUM_W (64),
        .DEN_W (33),
        .QUO_W (32)
    ) u_rdiv (
        .clk (clk),
        .en  (adv),
        .num (r1r2_3_reg),
        .den (rsum_3_reg),
        .quo (radius)
    );

    hcf_div #(
        .NUM_W (94),
        .DEN_W (64),
        .QUO_W (47)
    ) u_mdiv (
        .clk (clk),
        .en  (adv),
        .num ({e1e2_3_reg, 30'd0}),
        .den (den_3_reg),
        .quo (modulus)
    );

    // Overlap and modulus delay lines.
    logic [31:0] d_line_reg   [D_LEN];
    logic [46:0] mod_line_reg [MOD_LEN];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_line_reg[0]   <= d_3_reg;
            mod_line_reg[0] <= modulus;
            for (int i = 1; i < D_LEN; i++)
            begin
                d_line_reg[i] <= d_line_reg[i-1];
            end
            for (int i = 1; i < MOD_LEN; i++)
            begin
                mod_line_reg[i] <= mod_line_reg[i-1];
            end
        end
    end

    // sqrt(R*d), then sqrt(R)*d^1.5.
    logic [63:0] rd_reg;
    logic [31:0] root;
    logic [63:0] a_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg <= radius * d_line_reg[31];
        end
    end

    hcf_isqrt u_sqrt (
        .clk   (clk),
        .en    (adv),
        .value (rd_reg),
        .root  (root)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= root * d_line_reg[D_LEN-1];
        end
    end

    // Modulus times A as four partial products, then summed and doubled twice.
    logic [46:0]                 mod_tail;
    logic [63:0]                 pp_ll_reg;
    logic [62:0]                 pp_lh_reg;
    logic [46:0]                 pp_hl_reg;
    logic [45:0]                 pp_hh_reg;
    logic [hcf_pkg::PROD_W-1:0]  prod_next;
    logic [hcf_pkg::PROD_W-1:0]  prod4_reg;

    assign mod_tail = mod_line_reg[MOD_LEN-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_ll_reg <= mod_tail[31:0] * a_reg[31:0];
            pp_lh_reg <= mod_tail[31:0] * a_reg[62:32];
            pp_hl_reg <= mod_tail[46:32] * a_reg[31:0];
            pp_hh_reg <= mod_tail[46:32] * a_reg[62:32];
        end
    end

    assign prod_next = hcf_pkg::PROD_W'(pp_ll_reg)
                     + (hcf_pkg::PROD_W'(pp_lh_reg) << 32)
                     + (hcf_pkg::PROD_W'(pp_hl_reg) << 32)
                     + (hcf_pkg::PROD_W'(pp_hh_reg) << 64);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod4_reg <= {prod_next[hcf_pkg::PROD_W-3:0], 2'b00};
        end
    end

    // Division by three, one 16-bit digit per stage, top digit first.
    localparam int NS = hcf_pkg::DIV3_STEPS;

    logic [hcf_pkg::PROD_W-1:0] d3_val_reg  [NS];
    logic [1:0]                 d3_rem_reg  [NS];
    logic [hcf_pkg::PROD_W-1:0] d3_val_src  [NS];
    logic [1:0]                 d3_rem_src  [NS];
    logic [17:0]                d3_x        [NS];
    logic [32:0]                d3_scaled   [NS];
    logic [16:0]                d3_q0       [NS];
    logic [17:0]                d3_r        [NS];
    logic                       d3_ge       [NS];
    logic [15:0]                d3_q        [NS];
    logic [1:0]                 d3_rem_next [NS];

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (i == 0)
            begin
                d3_val_src[i] = prod4_reg;
                d3_rem_src[i] = '0;
            end
            else
            begin
                d3_val_src[i] = d3_val_reg[i-1];
                d3_rem_src[i] = d3_rem_reg[i-1];
            end
            d3_x[i]      = {d3_rem_src[i], d3_val_src[i][hcf_pkg::PROD_W-1 -: 16]};
            // The reciprocal estimate is at most one below the true quotient.
            d3_scaled[i] = d3_x[i] * hcf_pkg::DIV3_RECIP;
            d3_q0[i]     = d3_scaled[i][32:16];
            d3_r[i]      = d3_x[i] - ({d3_q0[i], 1'b0} + 18'(d3_q0[i]));
            d3_ge[i]     = (d3_r[i] >= 18'd3);
            d3_q[i]      = d3_q0[i][15:0] + 16'(d3_ge[i]);
            d3_rem_next[i] = d3_ge[i] ? 2'(d3_r[i] - 18'd3) : d3_r[i][1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NS; i++)
            begin
                d3_val_reg[i] <= {d3_val_src[i][hcf_pkg::PROD_W-17:0], d3_q[i]};
                d3_rem_reg[i] <= d3_rem_next[i];
            end
        end
    end

    // Control travels beside the data.
    hcf_pkg::item_ctl_t ctl_line_reg [CTL_LEN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_1_reg <= '0;
            ctl_2_reg <= '0;
            ctl_3_reg <= '0;
            for (int i = 0; i < CTL_LEN; i++)
            begin
                ctl_line_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            ctl_1_reg       <= ctl_1_next;
            ctl_2_reg       <= ctl_1_reg;
            ctl_3_reg       <= ctl_3_next;
            ctl_line_reg[0] <= ctl_3_reg;
            for (int i = 1; i < CTL_LEN; i++)
            begin
                ctl_line_reg[i] <= ctl_line_reg[i-1];
            end
        end
    end

    // Rescale to Q32.32 and saturate.
    hcf_pkg::item_ctl_t ctl_tail;
    logic [143:0]       ext;
    logic [143:0]       shifted;
    logic               sat;
    logic [63:0]        force_next;
    logic [1:0]         status_next;
    logic [63:0]        force_reg;
    logic [1:0]         status_reg;
    logic               m_tvalid_reg;

    assign ctl_tail = ctl_line_reg[CTL_LEN-1];
    assign ext      = {16'd0, d3_val_reg[NS-1], 16'd0};
    assign shifted  = ext >> SHR;
    assign sat      = |shifted[143:64];

    always_comb
    begin
        priority if (ctl_tail.no_overlap)
        begin
            force_next  = '0;
            status_next = hcf_pkg::STATUS_NO_OVERLAP;
        end
        else if (ctl_tail.zero_div)
        begin
            force_next  = '0;
            status_next = hcf_pkg::STATUS_ZERO_DIV;
        end
        else
        begin
            force_next  = sat ? '1 : shifted[63:0];
            status_next = hcf_pkg::STATUS_FORCE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_tvalid_reg <= ctl_tail.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            force_reg  <= force_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, status_reg, force_reg};

    `HCF_ASSERT_SAME(a_no_force_without_contact,
        m_tvalid && (status_reg != hcf_pkg::STATUS_FORCE), force_reg == '0,
        "force must be zero when no contact force is reported")
    `HCF_ASSERT_NEXT(a_stall_holds_pipe, !adv,
        $stable(ctl_tail) && $stable(m_tvalid),
        "pipeline moved while the output was stalled")
    `HCF_ASSERT_SAME(a_valid_from_pipe, $rose(m_tvalid), $past(ctl_tail.valid),
        "output valid rose without an item at the end of the pipeline")

endmodule

>>> tb/hcf_checker.sv
// ----------------------------------------------------------------------------
// hcf_checker
// Watches both streams of the contact force block, predicts each force from
// the accepted sphere pair and compares it with the result in order.
// ----------------------------------------------------------------------------
module hcf_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [191:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [71:0]  m_tdata,
    output int           fail_count,
    output int           pending
);

    logic [65:0] expected_forces[$];

    function automatic logic [65:0] predict_force(logic [191:0] pair);
        logic [63:0]  r1;
        logic [63:0]  r2;
        logic [63:0]  e1;
        logic [63:0]  e2;
        logic [63:0]  v1;
        logic [63:0]  v2;
        logic [31:0]  sep;
        logic [63:0]  d;
        logic [63:0]  rsum;
        logic [63:0]  den;
        logic [63:0]  radius;
        logic [127:0] num;
        logic [63:0]  modulus;
        logic [63:0]  root;
        logic [63:0]  prod;
        logic [127:0] p;
        logic [63:0]  force_val;
        int           shift;
        r1 = pair[31:0];
        r2 = pair[63:32];
        e1 = pair[95:64];
        e2 = pair[127:96];
        v1 = pair[142:128];
        v2 = pair[157:143];
        sep = pair[189:158];
        if (!sep[31])
            return {hcf_pkg::STATUS_NO_OVERLAP, 64'd0};
        d = {32'd0, -sep};
        if (d == 0)
            d = 64'd1 << 32;
        rsum = r1 + r2;
        den = e2 * ((64'd1 << 30) - v1 * v1) + e1 * ((64'd1 << 30) - v2 * v2);
        if (rsum == 0 || den == 0)
            return {hcf_pkg::STATUS_ZERO_DIV, 64'd0};
        radius = (r1 * r2) / rsum;
        num = {64'd0, e1 * e2} << 30;
        modulus = 64'(num / {64'd0, den});
        // Integer square root by bisection on 64-bit arguments.
        prod = radius * d;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            if (((root | (64'd1 << b)) * (root | (64'd1 << b))) <= prod)
                root = root | (64'd1 << b);
        end
        p = {64'd0, modulus} * {64'd0, 64'(root * d)};
        p = (p << 2) / 3;
        shift = 2 * FRAC_BITS - 32;
        if (shift > 0)
        begin
            p = p >> shift;
            force_val = (p[127:64] != 0) ? '1 : p[63:0];
        end
        else if (shift < 0)
        begin
            force_val = ((p >> (64 + shift)) != 0) ? '1 : p[63:0] << (-shift);
        end
        else
            force_val = (p[127:64] != 0) ? '1 : p[63:0];
        return {hcf_pkg::STATUS_FORCE, force_val};
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [65:0] want;
        if (!rst_n)
        begin
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_forces.insert(expected_forces.size(), predict_force(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_forces.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                else
                begin
                    want = expected_forces.pop_front();
                    if (m_tdata[63:0] !== want[63:0])
                        report_mismatch($sformatf("force %h, expected %h",
                            m_tdata[63:0], want[63:0]));
                    if (m_tdata[65:64] !== want[65:64])
                        report_mismatch($sformatf("status %0d, expected %0d",
                            m_tdata[65:64], want[65:64]));
                end
            end
            pending = expected_forces.size();
        end
    end

endmodule

>>> tb/tb_hertz_contact_force.sv
// ----------------------------------------------------------------------------
// tb_hertz_contact_force
// Drives directed and random sphere pairs into the contact force block with
// random gaps and output stalls; the checker compares every force.
// ----------------------------------------------------------------------------
module tb_hertz_contact_force;

    localparam int LATENCY = 79;
    localparam int CYCLE_LIMIT = 400000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    int           fail_count;
    int           pending;
    int           cycle_count;
    logic         hold_off_done;

    hertz_contact_force DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    hcf_checker checker_inst (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    function automatic logic [191:0] pack_pair(logic [31:0] r1, logic [31:0] r2,
        logic [31:0] e1, logic [31:0] e2, logic [14:0] v1, logic [14:0] v2,
        logic [31:0] sep);
        return {2'b00, sep, v2, v1, e2, e1, r2, r1};
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    // with valid still high, so pairs without a gap follow back to back.
    task automatic send_pair(logic [191:0] pair);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata <= pair;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_field32();
        unique case ($urandom_range(0, 4))
            0: return $urandom_range(0, 3);
            1: return '1 - $urandom_range(0, 3);
            2: return $urandom_range(1 << 12, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stalls plus one long hold-off once the sender is busy.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        hold_off_done = 1'b0;
        wait (rst_n);
        repeat (50) @(negedge clk);
        m_tready <= 1'b1;
        repeat (200) @(negedge clk);
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off_done = 1'b1;
        forever
        begin
            stall = gap_length();
            m_tready <= (stall == 0);
            @(negedge clk);
            if (stall > 0)
            begin
                repeat (stall - 1) @(negedge clk);
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_hertz_contact_force: FAIL");
            $finish;
        end
    end

    initial
    begin
        int drain;
        logic [14:0] v1;
        logic [14:0] v2;
        logic [31:0] sep;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: no overlap, zero divisors, extremes, overflow, tiny force.
        send_pair(pack_pair(32'h10000, 32'h10000, 1000, 1000, 0, 0, 0));
        send_pair(pack_pair('1, '1, '1, '1, '1, '1, 32'h7fffffff));
        send_pair(pack_pair(0, 0, 1000, 1000, 100, 100, -32'sd65536));
        send_pair(pack_pair(32'h10000, 32'h10000, 0, 0, 100, 100, -32'sd65536));
        send_pair(pack_pair(32'h10000, 0, 1000, 1000, 0, 0, -32'sd65536));
        send_pair(pack_pair(32'h10000, 32'h10000, 0, 1000, 0, 0, -32'sd65536));
        send_pair(pack_pair('1, '1, '1, '1, 0, 0, 32'h80000000));
        send_pair(pack_pair('1, '1, '1, '1, '1, '1, 32'h80000000));
        send_pair(pack_pair(1, 1, 1, 1, 0, 0, 32'hffffffff));
        send_pair(pack_pair(32'h10000, 32'h20000, 200000000, 70000000,
            15'd9830, 15'd11141, -32'sd6554));
        send_pair(pack_pair('1, 1, 1, '1, '1, 0, -32'sd1));
        send_pair(pack_pair(32'h8000, 32'h8000, 5000, 7000, 15'h4000, 15'h2000,
            32'hffff0000));
        send_pair(pack_pair(0, '1, '1, 0, 0, '1, -32'sd1000));

        for (int i = 0; i < 600; i++)
        begin
            v1 = ($urandom_range(0, 5) == 0) ? '1 : 15'($urandom);
            v2 = ($urandom_range(0, 5) == 0) ? '1 : 15'($urandom);
            sep = ($urandom_range(0, 4) == 0) ? rand_field32() | 32'h80000000 & $urandom
                : 32'h80000000 | rand_field32();
            send_pair(pack_pair(rand_field32(), rand_field32(), rand_field32(),
                rand_field32(), v1, v2, sep));
        end
        s_tvalid <= 1'b0;

        wait (hold_off_done && pending == 0);
        drain = 0;
        while (drain < LATENCY + 20)
        begin
            @(posedge clk);
            drain++;
        end
        if (fail_count == 0 && pending == 0)
            $display("tb_hertz_contact_force: PASS");
        else
            $display("tb_hertz_contact_force: FAIL");
        $finish;
    end

endmodule
